// ===== hw/rtl/avs_pkg.sv =====
// shared constants, payload types and the cordic arctangent table
`default_nettype none
package avs_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  // cordic datapath
  localparam int CORDIC_STEPS = 28;
  localparam int CS_W         = 34;
  localparam int Z_W          = 32;
  localparam int TRIG_W       = 32;
  localparam int PROD_W       = 48;
  localparam int SUM_W        = 50;
  localparam int MUF_W        = 48;
  localparam int TOT_W        = 50;
  localparam int DISP_W       = 32;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // divide by three through a reciprocal, exact for values below 2^20
  localparam logic [19:0] DIV3_RECIP = 20'd699051;
  localparam int          DIV3_SHIFT = 21;

  // noise amplitude path
  localparam int VAR_W  = 34;
  localparam int ROOT_W = 17;
  localparam int REM_W  = 21;
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // pipeline depth: lane stages end at LANE_LAT, merge adds MERGE_LAT
  localparam int LANE_LAT  = CORDIC_STEPS + 2;
  localparam int MERGE_LAT = 7;
  localparam int LAST_STG  = LANE_LAT + MERGE_LAT;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MOBILITY  = 1'b1;
  localparam logic [15:0] TIME_STEP_RST = 16'd655;
  localparam logic [15:0] MOBILITY_RST  = 16'd256;

  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_CELL   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [15:0]        speed_a;
    logic [15:0]        speed_b;
    logic [15:0]        speed_c;
    logic [15:0]        angle_a;
    logic [15:0]        angle_b;
    logic [15:0]        angle_c;
    logic [15:0]        rot_diffusion;
    logic signed [15:0] noise;
  } item_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic [15:0]        new_angle;
  } result_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [Z_W-1:0] atan_turn(input int unsigned idx);
    case (idx)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      24: return 32'd41;
      25: return 32'd20;
      26: return 32'd10;
      27: return 32'd5;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/avs_stream_if.sv =====
// valid/ready stream channel carrying one payload struct
`default_nettype none
interface avs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/avs_cordic_lane.sv =====
// one lane: pipelined cordic cos/sin of a phase, scaled by the lane's speed
`default_nettype none
module avs_cordic_lane #(
  parameter int ANGLE_BITS = avs_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [ANGLE_BITS-1:0]           phase,
  input  wire logic [15:0]                     speed,
  output logic signed [avs_pkg::PROD_W-1:0]    prod_c,
  output logic signed [avs_pkg::PROD_W-1:0]    prod_s
);
  import avs_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic [31:0] p32;
  logic signed [CS_W-1:0] x_q [1:CORDIC_STEPS];
  logic signed [CS_W-1:0] y_q [1:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_q [1:CORDIC_STEPS];
  logic [1:0]             quad_q [1:CORDIC_STEPS];
  logic [15:0]            spd_q [1:CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] xs, ys, cos_q, sin_q;

  assign p32 = {phase, {(32-ANGLE_BITS){1'b0}}};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] AT = atan_turn(i);
    logic signed [CS_W-1:0] x_c, y_c, dx, dy;
    logic signed [Z_W-1:0]  z_c;
    logic [1:0]             quad_c;
    logic [15:0]            spd_c;
    if (i == 0) begin : g_first
      assign x_c    = CORDIC_GAIN;
      assign y_c    = '0;
      assign z_c    = $signed({2'b00, p32[29:0]});
      assign quad_c = p32[31:30];
      assign spd_c  = speed;
    end else begin : g_next
      assign x_c    = x_q[i];
      assign y_c    = y_q[i];
      assign z_c    = z_q[i];
      assign quad_c = quad_q[i];
      assign spd_c  = spd_q[i];
    end
    assign dx = y_c >>> i;
    assign dy = x_c >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_c[Z_W-1]) begin
          x_q[i+1] <= x_c - dx;
          y_q[i+1] <= y_c + dy;
          z_q[i+1] <= z_c - AT;
        end else begin
          x_q[i+1] <= x_c + dx;
          y_q[i+1] <= y_c - dy;
          z_q[i+1] <= z_c + AT;
        end
        quad_q[i+1] <= quad_c;
        spd_q[i+1]  <= spd_c;
      end
    end
  end

  assign xs = x_q[CORDIC_STEPS][TRIG_W-1:0];
  assign ys = y_q[CORDIC_STEPS][TRIG_W-1:0];

  // quadrant fold-back, then the speed products
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_q[CORDIC_STEPS])
        QUAD_0:  begin cos_q <= xs;  sin_q <= ys;  end
        QUAD_1:  begin cos_q <= -ys; sin_q <= xs;  end
        QUAD_2:  begin cos_q <= -xs; sin_q <= -ys; end
        default: begin cos_q <= ys;  sin_q <= -xs; end
      endcase
      spd_q[CORDIC_STEPS+1] <= spd_q[CORDIC_STEPS];
    end
  end

  logic signed [TRIG_W+16:0] mc, ms;
  assign mc = $signed({1'b0, spd_q[CORDIC_STEPS+1]}) * cos_q;
  assign ms = $signed({1'b0, spd_q[CORDIC_STEPS+1]}) * sin_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c <= mc[PROD_W-1:0];
      prod_s <= ms[PROD_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/avs_sqrt_pipe.sv =====
// pipelined restoring integer square root, one result bit per stage
`default_nettype none
module avs_sqrt_pipe (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [avs_pkg::VAR_W-1:0]    radicand,
  output logic [avs_pkg::ROOT_W-1:0]        root
);
  import avs_pkg::*;

  logic [VAR_W-1:0]  v_q [1:ROOT_W];
  logic [ROOT_W-1:0] q_q [1:ROOT_W];
  logic [REM_W-1:0]  r_q [1:ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    logic [VAR_W-1:0]  v_c;
    logic [ROOT_W-1:0] q_c;
    logic [REM_W-1:0]  r_c, r_sh, trial;
    if (j == 0) begin : g_first
      assign v_c = radicand;
      assign q_c = '0;
      assign r_c = '0;
    end else begin : g_next
      assign v_c = v_q[j];
      assign q_c = q_q[j];
      assign r_c = r_q[j];
    end
    // bring down the next two radicand bits
    assign r_sh  = {r_c[REM_W-3:0], v_c[VAR_W-1 -: 2]};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, q_c, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        v_q[j+1] <= {v_c[VAR_W-3:0], 2'b00};
        if (r_sh >= trial) begin
          r_q[j+1] <= r_sh - trial;
          q_q[j+1] <= {q_c[ROOT_W-2:0], 1'b1};
        end else begin
          r_q[j+1] <= r_sh;
          q_q[j+1] <= {q_c[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_q[ROOT_W];
endmodule
`default_nettype wire

// ===== hw/rtl/avs_merge.sv =====
// merges the lane products: mean director, mobility term, dt scaling, saturation
`default_nettype none
module avs_merge (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [15:0]                        time_step,
  input  wire logic signed [avs_pkg::PROD_W-1:0]  prod [2][3],
  input  wire logic signed [avs_pkg::MUF_W-1:0]   muf [2],
  output logic signed [avs_pkg::DISP_W-1:0]       disp [2]
);
  import avs_pkg::*;

  localparam int M_W = SUM_W - 14;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [SUM_W-1:0] m1_sum;
    logic signed [MUF_W-1:0] m1_muf, m2_muf, m3_muf, m4_muf;
    logic [SUM_W-1:0]        abs_sum;
    logic [M_W-1:0]          m_c;
    logic [M_W-18:0]         m2_mh;
    logic [16:0]             m2_ml, m3_ml;
    logic                    m2_neg, m3_neg, m4_neg;
    logic [M_W+2:0]          qh_p;
    logic [17:0]             m3_qh, m4_qh, m4_q2;
    logic [18:0]             three_qh;
    logic [1:0]              m3_rh;
    logic [38:0]             q2_p;
    logic [35:0]             q_c;
    logic signed [TOT_W-1:0] d_c, m5_tot;
    logic [TOT_W-1:0]        mag_c;
    logic                    m6_neg;
    logic [TOT_W-25:0]       mh2;
    logic [23:0]             ml2;
    logic [TOT_W-9:0]        m6_ph;
    logic [39:0]             m6_pl;
    logic [40:0]             pl_rnd;
    logic [TOT_W-8:0]        q_mag;

    always_ff @(posedge clk) begin
      if (en) begin
        m1_sum <= SUM_W'(prod[a][0]) + SUM_W'(prod[a][1]) + SUM_W'(prod[a][2]);
        m1_muf <= muf[a];
      end
    end

    // truncate toward zero: work on the magnitude
    assign abs_sum = m1_sum[SUM_W-1] ? SUM_W'(-m1_sum) : SUM_W'(m1_sum);
    assign m_c     = abs_sum[SUM_W-1:14];

    always_ff @(posedge clk) begin
      if (en) begin
        m2_mh  <= m_c[M_W-1:17];
        m2_ml  <= m_c[16:0];
        m2_neg <= m1_sum[SUM_W-1];
        m2_muf <= m1_muf;
      end
    end

    assign qh_p     = m2_mh * DIV3_RECIP;
    assign three_qh = {qh_p[DIV3_SHIFT +: 18], 1'b0} + 19'(qh_p[DIV3_SHIFT +: 18]);

    always_ff @(posedge clk) begin
      if (en) begin
        m3_qh  <= qh_p[DIV3_SHIFT +: 18];
        m3_rh  <= 2'(19'(m2_mh) - three_qh);
        m3_ml  <= m2_ml;
        m3_neg <= m2_neg;
        m3_muf <= m2_muf;
      end
    end

    assign q2_p = {m3_rh, m3_ml} * DIV3_RECIP;

    always_ff @(posedge clk) begin
      if (en) begin
        m4_qh  <= m3_qh;
        m4_q2  <= q2_p[DIV3_SHIFT +: 18];
        m4_neg <= m3_neg;
        m4_muf <= m3_muf;
      end
    end

    assign q_c = {m4_qh, 17'b0} + 36'(m4_q2);
    assign d_c = m4_neg ? -$signed(TOT_W'(q_c)) : $signed(TOT_W'(q_c));

    always_ff @(posedge clk) begin
      if (en) begin
        m5_tot <= d_c + TOT_W'(m4_muf);
      end
    end

    // dt times magnitude, cut at bit 24 into two partial products
    assign mag_c = m5_tot[TOT_W-1] ? TOT_W'(-m5_tot) : TOT_W'(m5_tot);
    assign mh2   = mag_c[TOT_W-1:24];
    assign ml2   = mag_c[23:0];

    always_ff @(posedge clk) begin
      if (en) begin
        m6_ph  <= mh2 * time_step;
        m6_pl  <= ml2 * time_step;
        m6_neg <= m5_tot[TOT_W-1];
      end
    end

    assign pl_rnd = 41'(m6_pl) + 41'(24'h800000);
    assign q_mag  = (TOT_W-7)'(m6_ph) + (TOT_W-7)'(pl_rnd[40:24]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (m6_neg) begin
          if (q_mag > (TOT_W-7)'(64'h8000_0000)) disp[a] <= 32'sh8000_0000;
          else disp[a] <= DISP_W'(-$signed({1'b0, q_mag}));
        end else begin
          if (q_mag > (TOT_W-7)'(64'h7FFF_FFFF)) disp[a] <= 32'sh7FFF_FFFF;
          else disp[a] <= DISP_W'(q_mag);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/active_vertex_euler_step_unit.sv =====
// top level: input stage, three cordic lanes, merge, director noise path, output
//
//  channel    | dir | handshake         | payload
//  -----------+-----+-------------------+--------------------------------------
//  item_in    | in  | valid / ready     | avs_pkg::item_t (mode, force, speeds,
//             |     |                   | angles, rot_diffusion, noise)
//  result_out | out | valid / ready     | avs_pkg::result_t (disp_x, disp_y,
//             |     |                   | new_angle)
//  cfg        | in  | cfg_we            | cfg_index, cfg_data (16 bits)
//
// one item per cycle while no result waits at the output; each result passes the input
// stage, the 28 cordic stages of the lanes, mapping, product and the 7 merge stages.
// the whole pipeline holds while a result waits at the output, so the next item
// is taken in the same cycle that the waiting result is transferred.
// synchronous reset clears the stage valid bits and loads the register defaults.
`default_nettype none
module active_vertex_euler_step_unit #(
  parameter int ANGLE_BITS = avs_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  avs_stream_if.sink                             item_in,
  avs_stream_if.source                           result_out,
  input  wire logic                              cfg_we,
  input  wire logic [avs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  import avs_pkg::*;

  localparam int SH       = 56 - ANGLE_BITS;
  localparam int ROOT_STG = ROOT_W;
  localparam int ANG_STG  = ROOT_STG + 5;

  logic [15:0] time_step, mobility;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      mobility  <= MOBILITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data;
        REG_MOBILITY:  mobility  <= cfg_data;
        default: ;
      endcase
    end
  end

  // one enable for every stage: move on unless a result is held at the output
  logic vld [0:LAST_STG];
  logic mode_d [0:LAST_STG];
  assign adv           = !vld[LAST_STG] || result_out.ready;
  assign item_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST_STG; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= item_in.valid;
      for (int k = 1; k <= LAST_STG; k++) vld[k] <= vld[k-1];
    end
  end

  // input stage
  logic [ANGLE_BITS-1:0]  ph_in [3];
  logic [ANGLE_BITS-1:0]  ph0 [3];
  logic [15:0]            spd0 [3];
  logic [31:0]            ang_ext [3];
  logic signed [MUF_W:0]  mfx_c, mfy_c;
  logic [31:0]            var_c;
  logic [VAR_W-1:0]       var0;

  assign ang_ext[0] = {16'b0, item_in.data.angle_a};
  assign ang_ext[1] = {16'b0, item_in.data.angle_b};
  assign ang_ext[2] = {16'b0, item_in.data.angle_c};
  for (genvar l = 0; l < 3; l++) begin : g_mask
    assign ph_in[l] = ang_ext[l][ANGLE_BITS-1:0];
  end
  assign mfx_c = $signed({1'b0, mobility}) * item_in.data.force_x;
  assign mfy_c = $signed({1'b0, mobility}) * item_in.data.force_y;
  assign var_c = time_step * item_in.data.rot_diffusion;

  logic signed [MUF_W-1:0] mufx_d [0:LANE_LAT];
  logic signed [MUF_W-1:0] mufy_d [0:LANE_LAT];
  logic signed [15:0]      noise_d [0:ROOT_STG];
  logic [ANGLE_BITS-1:0]   angle_d [0:ANG_STG-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_d[0]  <= item_in.data.mode;
      ph0        <= ph_in;
      spd0[0]    <= item_in.data.speed_a;
      spd0[1]    <= item_in.data.speed_b;
      spd0[2]    <= item_in.data.speed_c;
      mufx_d[0]  <= mfx_c[MUF_W-1:0];
      mufy_d[0]  <= mfy_c[MUF_W-1:0];
      var0       <= {1'b0, var_c, 1'b0};
      noise_d[0] <= item_in.data.noise;
      angle_d[0] <= ph_in[0];
      for (int k = 1; k <= LAST_STG; k++) mode_d[k] <= mode_d[k-1];
      for (int k = 1; k <= LANE_LAT; k++) begin
        mufx_d[k] <= mufx_d[k-1];
        mufy_d[k] <= mufy_d[k-1];
      end
      for (int k = 1; k <= ROOT_STG; k++) noise_d[k] <= noise_d[k-1];
      for (int k = 1; k < ANG_STG; k++) angle_d[k] <= angle_d[k-1];
    end
  end

  // vertex path: three lanes and the merge
  logic signed [PROD_W-1:0] prod [2][3];
  logic signed [MUF_W-1:0]  muf [2];
  logic signed [DISP_W-1:0] disp [2];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    avs_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane (
      .clk    (clk),
      .en     (adv),
      .phase  (ph0[l]),
      .speed  (spd0[l]),
      .prod_c (prod[0][l]),
      .prod_s (prod[1][l])
    );
  end

  assign muf[0] = mufx_d[LANE_LAT];
  assign muf[1] = mufy_d[LANE_LAT];

  avs_merge u_merge (
    .clk       (clk),
    .en        (adv),
    .time_step (time_step),
    .prod      (prod),
    .muf       (muf),
    .disp      (disp)
  );

  // cell path: noise amplitude, phase step, wrapped phase
  logic [ROOT_W-1:0]        root;
  logic signed [ROOT_W+16:0] nprod_c;
  logic signed [ROOT_W+16:0] nprod_q;
  logic [31:0]              nmag_q;
  logic                     nneg19, nneg20, nneg21;
  logic [45:0]              pph_q, ppl_q;
  logic [62:0]              full_c;
  logic [ANGLE_BITS-1:0]    step_q;
  logic [ANGLE_BITS-1:0]    ang_d [ANG_STG:LAST_STG];

  avs_sqrt_pipe u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (var0),
    .root     (root)
  );

  assign nprod_c = $signed({1'b0, root}) * noise_d[ROOT_STG];
  assign full_c  = {1'b0, pph_q, 16'b0} + 63'(ppl_q) + (63'(1) << (SH - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      nprod_q <= nprod_c;
      nneg19  <= nprod_q[ROOT_W+16];
      nmag_q  <= nprod_q[ROOT_W+16] ? 32'(-nprod_q) : 32'(nprod_q);
      nneg20  <= nneg19;
      pph_q   <= nmag_q[31:16] * INV_TWO_PI;
      ppl_q   <= nmag_q[15:0] * INV_TWO_PI;
      nneg21  <= nneg20;
      step_q  <= full_c[SH +: ANGLE_BITS];
      ang_d[ANG_STG] <= nneg21 ? angle_d[ANG_STG-1] - step_q
                               : angle_d[ANG_STG-1] + step_q;
      for (int k = ANG_STG + 1; k <= LAST_STG; k++) ang_d[k] <= ang_d[k-1];
    end
  end

  // output stage: unused fields forced to zero
  logic [31:0] ang_out;
  assign ang_out = {{(32-ANGLE_BITS){1'b0}}, ang_d[LAST_STG]};

  assign result_out.valid          = vld[LAST_STG];
  assign result_out.data.disp_x    = (mode_d[LAST_STG] == MODE_VERTEX) ? disp[0] : '0;
  assign result_out.data.disp_y    = (mode_d[LAST_STG] == MODE_VERTEX) ? disp[1] : '0;
  assign result_out.data.new_angle = (mode_d[LAST_STG] == MODE_CELL) ? ang_out[15:0] : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/avs_checker.sv =====
// port-level checks on the top level, bound to it
`default_nettype none
module avs_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic signed [31:0]  disp_x,
  input wire logic signed [31:0]  disp_y,
  input wire logic [15:0]         new_angle
);
  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(disp_x) && $stable(disp_y)
      && $stable(new_angle))
    else $error("result changed while stalled");

  // input is taken exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output state");

  // a cell result never carries a displacement
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_angle != 16'd0 |-> disp_x == 32'sd0 && disp_y == 32'sd0)
    else $error("displacement and phase both set");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind active_vertex_euler_step_unit avs_checker u_avs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .disp_x    (result_out.data.disp_x),
  .disp_y    (result_out.data.disp_y),
  .new_angle (result_out.data.new_angle)
);
`default_nettype wire

// ===== bench/active_vertex_euler_step_unit_tb.sv =====
// self-checking bench for the active vertex euler step unit: directed table, then random phases
`default_nettype none
module active_vertex_euler_step_unit_tb;
  import avs_pkg::*;

  localparam int PIPE_WAIT = 45;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 115;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint unsigned TURN_RECIP = 64'd683565276;
  localparam longint ARC_TURN [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  avs_stream_if #(.payload_t(item_t)) item_ch ();
  avs_stream_if #(.payload_t(result_t)) result_ch ();

  active_vertex_euler_step_unit uut (
    .clk(clk), .rst(rst), .item_in(item_ch), .result_out(result_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor register copies
  logic [15:0] dt_reg;
  logic [15:0] mu_reg;

  result_t expected_results[$];
  int err_count;
  int items_sent;
  int results_seen;
  int idle_cycles;
  bit no_idle;
  bit hold_request;

  typedef struct {
    bit          is_cfg;
    logic        idx;
    logic [15:0] val;
    item_t       it;
    bit          known;
    result_t     res;
  } row_t;

  // cos/sin of a 16-bit phase, both Q2.30
  task automatic director_trig(input logic [15:0] ph, output longint c, output longint s);
    logic [31:0] p32;
    longint x, y, z, dx, dy;
    p32 = {ph, 16'h0};
    x = ROT_GAIN;
    y = 0;
    z = longint'(p32[29:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARC_TURN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARC_TURN[i];
      end
    end
    case (p32[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q.24 total scaled by dt, rounded half away from zero and clipped to Q16.16
  function automatic logic [31:0] scaled_disp(input longint total);
    longint unsigned mag, q;
    bit neg;
    neg = total < 0;
    mag = neg ? longint'(-total) : total;
    q = (mag * longint'(dt_reg) + (64'd1 << 23)) >> 24;
    if (neg) return (q > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(q));
    return (q > 64'd2147483647) ? 32'h7fff_ffff : 32'(q);
  endfunction

  task automatic euler_result(input item_t it, output result_t r);
    longint c, s, sx, sy, tx, ty, prod;
    longint unsigned variance, amp, mag, stp;
    logic [15:0] spd [3];
    logic [15:0] ang [3];
    r = '0;
    if (it.mode == MODE_VERTEX) begin
      spd = '{it.speed_a, it.speed_b, it.speed_c};
      ang = '{it.angle_a, it.angle_b, it.angle_c};
      sx = 0;
      sy = 0;
      for (int k = 0; k < 3; k++) begin
        director_trig(ang[k], c, s);
        sx = sx + longint'(spd[k]) * c;
        sy = sy + longint'(spd[k]) * s;
      end
      tx = sx / 64'sd49152 + longint'(mu_reg) * longint'(it.force_x);
      ty = sy / 64'sd49152 + longint'(mu_reg) * longint'(it.force_y);
      r.disp_x = scaled_disp(tx);
      r.disp_y = scaled_disp(ty);
    end else begin
      variance = 2 * longint'(dt_reg) * longint'(it.rot_diffusion);
      amp = int_root(variance);
      prod = longint'(amp) * longint'(it.noise);
      mag = (prod < 0) ? longint'(-prod) : prod;
      stp = (mag * TURN_RECIP + (64'd1 << 39)) >> 40;
      r.new_angle = (prod < 0) ? 16'(it.angle_a - stp) : 16'(it.angle_a + stp);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, results_seen);
    err_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictions are queued on input transfers, checked on output transfers
  always @(posedge clk) begin
    result_t r, want;
    if (!rst && item_ch.valid && item_ch.ready) begin
      euler_result(item_ch.data, r);
      expected_results.push_back(r);
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      r = result_ch.data;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", r, 0);
      end else begin
        want = expected_results.pop_front();
        if (r.disp_x !== want.disp_x) report_mismatch("disp_x", r.disp_x, want.disp_x);
        if (r.disp_y !== want.disp_y) report_mismatch("disp_y", r.disp_y, want.disp_y);
        if (r.new_angle !== want.new_angle)
          report_mismatch("new_angle", r.new_angle, want.new_angle);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        result_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.data <= it;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIME_STEP) dt_reg = val;
    else mu_reg = val;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'hffff;
      1: return 16'h0;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.mode = ($urandom_range(0, 1) == 1) ? MODE_CELL : MODE_VERTEX;
    it.force_x = pick32();
    it.force_y = pick32();
    it.speed_a = pick16();
    it.speed_b = pick16();
    it.speed_c = pick16();
    it.angle_a = pick16();
    it.angle_b = pick16();
    it.angle_c = pick16();
    it.rot_diffusion = pick16();
    it.noise = pick16();
    return it;
  endfunction

  function automatic row_t item_row(input item_t it);
    row_t rw;
    rw = '{0, 0, 0, it, 0, '0};
    return rw;
  endfunction

  function automatic row_t known_row(input item_t it, input result_t r);
    row_t rw;
    rw = '{0, 0, 0, it, 1, r};
    return rw;
  endfunction

  function automatic row_t cfg_row(input logic idx, input logic [15:0] val);
    row_t rw;
    rw = '{1, idx, val, '0, 0, '0};
    return rw;
  endfunction

  row_t dir_rows[$];
  logic [15:0] phase_dt [6] = '{16'd655, 16'd0, 16'hffff, 16'd1, 16'd9000, 16'd30000};
  logic [15:0] phase_mu [6] = '{16'd256, 16'd1234, 16'hffff, 16'd0, 16'd40, 16'd700};

  initial begin
    item_t it;
    result_t r, want;
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_TIME_STEP;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    dt_reg = TIME_STEP_RST;
    mu_reg = MOBILITY_RST;
    err_count = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    no_idle = 0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: zero item, cell with no noise, vertex extremes, saturation
    it = '0;
    dir_rows.push_back(known_row(it, '0));
    it.mode = MODE_CELL; it.angle_a = 16'h1234; it.rot_diffusion = 16'hffff;
    dir_rows.push_back(known_row(it, '{0, 0, 16'h1234}));
    it.noise = 16'sh7fff; it.rot_diffusion = 16'h0; it.angle_a = 16'hffff;
    dir_rows.push_back(known_row(it, '{0, 0, 16'hffff}));
    it.rot_diffusion = 16'hffff;
    dir_rows.push_back(item_row(it));
    it.noise = 16'sh8000; it.angle_a = 16'h0;
    dir_rows.push_back(item_row(it));
    it.noise = 16'sh0001; it.rot_diffusion = 16'h0001;
    dir_rows.push_back(item_row(it));
    it = '0;
    it.speed_a = 16'hffff; it.speed_b = 16'hffff; it.speed_c = 16'hffff;
    dir_rows.push_back(item_row(it));
    for (int q = 0; q < 4; q++) begin
      it.angle_a = 16'(q * 16384); it.angle_b = 16'(q * 16384 + 8192);
      it.angle_c = 16'(16'hffff - q * 16384);
      dir_rows.push_back(item_row(it));
    end
    it = '0;
    it.force_x = 32'sh7fff_ffff; it.force_y = 32'sh8000_0000;
    dir_rows.push_back(item_row(it));
    it.force_x = -32'sd1; it.force_y = 32'sd1;
    dir_rows.push_back(item_row(it));
    dir_rows.push_back(cfg_row(REG_TIME_STEP, 16'hffff));
    dir_rows.push_back(cfg_row(REG_MOBILITY, 16'hffff));
    it = '0;
    it.force_x = 32'sh7fff_ffff; it.force_y = 32'sh8000_0000;
    dir_rows.push_back(known_row(it, '{32'sh7fff_ffff, 32'sh8000_0000, 0}));
    it.speed_a = 16'hffff; it.speed_b = 16'hffff; it.speed_c = 16'hffff;
    dir_rows.push_back(item_row(it));
    dir_rows.push_back(cfg_row(REG_TIME_STEP, 16'h0));
    dir_rows.push_back(known_row(it, '0));
    it = '0; it.mode = MODE_CELL; it.angle_a = 16'h4321; it.rot_diffusion = 16'hffff;
    it.noise = 16'sh7fff;
    dir_rows.push_back(known_row(it, '{0, 0, 16'h4321}));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (dir_rows[i].known) begin
          euler_result(dir_rows[i].it, want);
          if (want !== dir_rows[i].res) report_mismatch("table row", i, want);
        end
        send_item(dir_rows[i].it);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_TIME_STEP, phase_dt[ph]);
      write_reg(REG_MOBILITY, phase_mu[ph]);
      no_idle = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) hold_request = 1;
        if (ph == 4 && n == 60) no_idle = 1;
        if (ph == 4 && n == 90) no_idle = 0;
        send_item(random_item());
      end
    end
    no_idle = 0;
    item_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    $display("covered %0d items and %0d results over 6 register settings", items_sent,
             results_seen);
    $display("both modes, field extremes, saturation, zero step and a long output hold-off");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", err_count);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
